// File: rtl/psls_pkg.sv
package psls_pkg;

   localparam int NUM_SLOTS = 8;
   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int ID_W = 8;
   localparam int CLK_W = 10;
   localparam int DATA_W = 32;
   localparam int SUM_W = 64;

   localparam logic [CLK_W-1:0] FALLBACK_MHZ = 10'd480;

   localparam int REC_STEPS = DATA_W;
   localparam int REP_STEPS = SUM_W;
   localparam int STEP_W = $clog2(REP_STEPS);

   localparam logic KIND_RECORD = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_REC_DIV,
      S_REC_UPD,
      S_REP_LD,
      S_REP_DIV,
      S_REP_CAP,
      S_REP_OUT
   } psls_state_type;

   typedef struct packed {
      logic              load_rec;
      logic              load_rep;
      logic              step;
      logic              update;
      logic              capture;
      logic              clear;
      logic [SLOT_W-1:0] slot;
   } psls_cmd_type;

endpackage

// File: rtl/psls_ctrl.sv
module psls_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_kind,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output psls_pkg::psls_cmd_type cmd
);

   psls_pkg::psls_state_type state_ff, state_in;
   logic [psls_pkg::STEP_W-1:0] step_ff, step_in;
   logic [psls_pkg::SLOT_W-1:0] idx_ff, idx_in;
   logic last_slot;
   logic rec_done;
   logic rep_done;

   assign last_slot = (idx_ff == psls_pkg::SLOT_W'(psls_pkg::NUM_SLOTS - 1));
   assign rec_done = (step_ff == psls_pkg::STEP_W'(psls_pkg::REC_STEPS - 1));
   assign rep_done = (step_ff == psls_pkg::STEP_W'(psls_pkg::REP_STEPS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         psls_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = (req_kind == psls_pkg::KIND_REPORT) ? psls_pkg::S_REP_LD
                                                              : psls_pkg::S_REC_DIV;
            end
         end
         psls_pkg::S_REC_DIV: begin
            if (rec_done) state_in = psls_pkg::S_REC_UPD;
         end
         psls_pkg::S_REC_UPD: state_in = psls_pkg::S_IDLE;
         psls_pkg::S_REP_LD:  state_in = psls_pkg::S_REP_DIV;
         psls_pkg::S_REP_DIV: begin
            if (rep_done) state_in = psls_pkg::S_REP_CAP;
         end
         psls_pkg::S_REP_CAP: state_in = psls_pkg::S_REP_OUT;
         psls_pkg::S_REP_OUT: begin
            if (rsp_ready) state_in = last_slot ? psls_pkg::S_IDLE : psls_pkg::S_REP_LD;
         end
         default: state_in = psls_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      step_in = step_ff;
      idx_in = idx_ff;
      if (state_ff == psls_pkg::S_REC_DIV || state_ff == psls_pkg::S_REP_DIV) begin
         step_in = step_ff + psls_pkg::STEP_W'(1);
         if ((state_ff == psls_pkg::S_REC_DIV && rec_done) ||
             (state_ff == psls_pkg::S_REP_DIV && rep_done)) begin
            step_in = '0;
         end
      end
      if (state_ff == psls_pkg::S_REP_OUT && rsp_ready) begin
         idx_in = last_slot ? '0 : idx_ff + psls_pkg::SLOT_W'(1);
      end
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd = '0;
      cmd.slot = idx_ff;
      case (state_ff)
         psls_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.load_rec = req_valid && (req_kind == psls_pkg::KIND_RECORD);
         end
         psls_pkg::S_REC_DIV: cmd.step = 1'b1;
         psls_pkg::S_REC_UPD: cmd.update = 1'b1;
         psls_pkg::S_REP_LD:  cmd.load_rep = 1'b1;
         psls_pkg::S_REP_DIV: cmd.step = 1'b1;
         psls_pkg::S_REP_CAP: cmd.capture = 1'b1;
         psls_pkg::S_REP_OUT: begin
            rsp_valid = 1'b1;
            cmd.clear = rsp_ready && last_slot;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psls_pkg::S_IDLE;
         step_ff <= '0;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         idx_ff <= idx_in;
      end
   end

endmodule

// File: rtl/psls_dpath.sv
module psls_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  psls_pkg::psls_cmd_type             cmd,
   input  logic                               csr_wr_en,
   input  logic [psls_pkg::CLK_W-1:0]         csr_wr_data,
   input  logic [psls_pkg::ID_W-1:0]          req_slot_id,
   input  logic [psls_pkg::DATA_W-1:0]        req_start_cycle,
   input  logic [psls_pkg::DATA_W-1:0]        req_end_cycle,
   output logic [psls_pkg::ID_W-1:0]          rsp_report_slot,
   output logic [psls_pkg::DATA_W-1:0]        rsp_max_us,
   output logic [psls_pkg::DATA_W-1:0]        rsp_avg_us,
   output logic [psls_pkg::DATA_W-1:0]        rsp_sample_count,
   output logic                               rsp_last
);

   localparam int DW = psls_pkg::DATA_W;
   localparam int SW = psls_pkg::SUM_W;
   localparam int NS = psls_pkg::NUM_SLOTS;

   logic [psls_pkg::CLK_W-1:0] clk_mhz_ff;

   logic [DW-1:0] max_ff [NS];
   logic [SW-1:0] sum_ff [NS];
   logic [DW-1:0] cnt_ff [NS];

   logic [SW-1:0] dvd_ff, dvd_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dsr_ff, dsr_in;
   logic [psls_pkg::SLOT_W-1:0] slot_ff;
   logic slot_ok_ff;

   logic [psls_pkg::ID_W-1:0] rsp_slot_ff;
   logic [DW-1:0] rsp_max_ff;
   logic [DW-1:0] rsp_avg_ff;
   logic [DW-1:0] rsp_cnt_ff;
   logic rsp_last_ff;

   logic [psls_pkg::SLOT_W-1:0] rd_idx;
   logic [DW-1:0] max_rd;
   logic [SW-1:0] sum_rd;
   logic [DW-1:0] cnt_rd;
   logic [DW:0] trial;
   logic [DW:0] diff;
   logic fits;
   logic [psls_pkg::CLK_W-1:0] divisor;
   logic [DW-1:0] us;
   logic [SW:0] sum_ext;
   logic [SW-1:0] sum_new;
   logic [DW-1:0] max_new;
   logic [DW-1:0] cnt_new;
   logic [DW-1:0] avg;

   assign rd_idx = cmd.update ? slot_ff : cmd.slot;
   assign max_rd = max_ff[rd_idx];
   assign sum_rd = sum_ff[rd_idx];
   assign cnt_rd = cnt_ff[rd_idx];

   assign divisor = (clk_mhz_ff == '0) ? psls_pkg::FALLBACK_MHZ : clk_mhz_ff;

   // One radix-2 restoring step per cycle; quotient bits shift into the dividend.
   assign trial = {rem_ff, dvd_ff[SW-1]};
   assign diff = trial - {1'b0, dsr_ff};
   assign fits = (trial >= {1'b0, dsr_ff});

   always_comb begin
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      if (cmd.load_rec) begin
         dvd_in = {req_end_cycle - req_start_cycle, DW'(0)};
         rem_in = '0;
         dsr_in = DW'(divisor);
      end else if (cmd.load_rep) begin
         dvd_in = sum_rd;
         rem_in = '0;
         dsr_in = cnt_rd;
      end else if (cmd.step) begin
         dvd_in = {dvd_ff[SW-2:0], fits};
         rem_in = fits ? diff[DW-1:0] : trial[DW-1:0];
      end
   end

   assign us = dvd_ff[DW-1:0];
   assign sum_ext = {1'b0, sum_rd} + {(SW + 1 - DW)'(0), us};
   assign sum_new = sum_ext[SW] ? {SW{1'b1}} : sum_ext[SW-1:0];
   assign max_new = (us > max_rd) ? us : max_rd;
   assign cnt_new = (cnt_rd == {DW{1'b1}}) ? cnt_rd : cnt_rd + DW'(1);

   always_comb begin
      if (cnt_rd == '0) begin
         avg = '0;
      end else if (dvd_ff[SW-1:DW] != '0) begin
         avg = {DW{1'b1}};
      end else begin
         avg = dvd_ff[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_mhz_ff <= psls_pkg::FALLBACK_MHZ;
      end else if (csr_wr_en) begin
         clk_mhz_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      if (cmd.load_rec) begin
         slot_ff <= req_slot_id[psls_pkg::SLOT_W-1:0];
         slot_ok_ff <= (req_slot_id < psls_pkg::ID_W'(NS));
      end
      if (cmd.capture) begin
         rsp_slot_ff <= psls_pkg::ID_W'(cmd.slot);
         rsp_max_ff <= max_rd;
         rsp_avg_ff <= avg;
         rsp_cnt_ff <= cnt_rd;
         rsp_last_ff <= (cmd.slot == psls_pkg::SLOT_W'(NS - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < NS; i++) begin
            max_ff[i] <= '0;
            sum_ff[i] <= '0;
            cnt_ff[i] <= '0;
         end
      end else if (cmd.update && slot_ok_ff) begin
         max_ff[slot_ff] <= max_new;
         sum_ff[slot_ff] <= sum_new;
         cnt_ff[slot_ff] <= cnt_new;
      end
   end

   assign rsp_report_slot = rsp_slot_ff;
   assign rsp_max_us = rsp_max_ff;
   assign rsp_avg_us = rsp_avg_ff;
   assign rsp_sample_count = rsp_cnt_ff;
   assign rsp_last = rsp_last_ff;

endmodule

// File: rtl/per_slot_latency_statistics_unit.sv
// Per-slot latency statistics. A record transfer (kind 0) turns end minus start cycles into
// microseconds by dividing by csr_wr_data's clock in MHz (0 means 480) and folds the value
// into the slot's maximum, saturating sum and saturating count; ids at or beyond the slot
// count are dropped. A record keeps req_ready low from acceptance until the 32 steps of the
// shared one-bit-per-cycle divider and the table update are done. A report transfer (kind 1)
// yields one response per slot in slot order, the last one flagged, and clears the table
// after the last response is taken. For each slot the same divider forms the average in
// 64 steps before the response is offered, which then waits for rsp_ready. The table is
// cleared by reset and holds no item while it is busy.
module per_slot_latency_statistics_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [psls_pkg::CLK_W-1:0]         csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_kind,
   input  logic [psls_pkg::ID_W-1:0]          req_slot_id,
   input  logic [psls_pkg::DATA_W-1:0]        req_start_cycle,
   input  logic [psls_pkg::DATA_W-1:0]        req_end_cycle,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [psls_pkg::ID_W-1:0]          rsp_report_slot,
   output logic [psls_pkg::DATA_W-1:0]        rsp_max_us,
   output logic [psls_pkg::DATA_W-1:0]        rsp_avg_us,
   output logic [psls_pkg::DATA_W-1:0]        rsp_sample_count,
   output logic                               rsp_last
);

   psls_pkg::psls_cmd_type cmd;

   psls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   psls_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_slot_id      (req_slot_id),
      .req_start_cycle  (req_start_cycle),
      .req_end_cycle    (req_end_cycle),
      .rsp_report_slot  (rsp_report_slot),
      .rsp_max_us       (rsp_max_us),
      .rsp_avg_us       (rsp_avg_us),
      .rsp_sample_count (rsp_sample_count),
      .rsp_last         (rsp_last)
   );

   a_busy_while_responding: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("Request accepted while a response is pending.");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready && !rsp_valid)
      else $error("Block did not return to idle after the last response.");

   a_record_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == psls_pkg::KIND_RECORD) |=> !rsp_valid)
      else $error("Record transfer produced a response.");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import psls_pkg::*;

   localparam int DRAIN_CYCLES = 40;
   localparam int LONG_HOLD_CYCLES = 1500;
   localparam int IDLE_PERCENT = 17;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_ITEMS = 55;

   typedef struct packed {
      logic [ID_W-1:0]   slot;
      logic [DATA_W-1:0] max_us;
      logic [DATA_W-1:0] avg_us;
      logic [DATA_W-1:0] sample_count;
      logic              last;
   } slot_report_type;

   class latency_stats_board;
      logic [CLK_W-1:0]  clock_mhz;
      logic [DATA_W-1:0] max_tab [NUM_SLOTS];
      logic [SUM_W-1:0]  sum_tab [NUM_SLOTS];
      logic [DATA_W-1:0] count_tab [NUM_SLOTS];
      slot_report_type   pending_reports [$];
      int                failures;

      function new();
         clock_mhz = FALLBACK_MHZ;
         failures = 0;
         clear_slots();
      endfunction

      function void clear_slots();
         for (int i = 0; i < NUM_SLOTS; i++) begin
            max_tab[i] = '0;
            sum_tab[i] = '0;
            count_tab[i] = '0;
         end
      endfunction

      function void note_request(logic kind, logic [ID_W-1:0] slot_id,
                                 logic [DATA_W-1:0] start_cycle,
                                 logic [DATA_W-1:0] end_cycle);
         logic [DATA_W-1:0] divisor;
         logic [DATA_W-1:0] elapsed_cycles;
         logic [DATA_W-1:0] elapsed_us;
         logic [SUM_W-1:0]  avg;
         logic [SLOT_W-1:0] idx;
         slot_report_type   entry;
         if (kind == KIND_RECORD) begin
            divisor = (clock_mhz == '0) ? DATA_W'(FALLBACK_MHZ) : DATA_W'(clock_mhz);
            elapsed_cycles = end_cycle - start_cycle;
            elapsed_us = elapsed_cycles / divisor;
            if (slot_id < NUM_SLOTS) begin
               idx = slot_id[SLOT_W-1:0];
               if (elapsed_us > max_tab[idx])
                  max_tab[idx] = elapsed_us;
               if (sum_tab[idx] > {SUM_W{1'b1}} - SUM_W'(elapsed_us))
                  sum_tab[idx] = {SUM_W{1'b1}};
               else
                  sum_tab[idx] = sum_tab[idx] + SUM_W'(elapsed_us);
               if (count_tab[idx] != {DATA_W{1'b1}})
                  count_tab[idx] = count_tab[idx] + 1'b1;
            end
         end else begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               avg = '0;
               if (count_tab[i] != '0) begin
                  avg = sum_tab[i] / SUM_W'(count_tab[i]);
                  if (avg > SUM_W'({DATA_W{1'b1}}))
                     avg = SUM_W'({DATA_W{1'b1}});
               end
               entry.slot = ID_W'(i);
               entry.max_us = max_tab[i];
               entry.avg_us = avg[DATA_W-1:0];
               entry.sample_count = count_tab[i];
               entry.last = (i == NUM_SLOTS - 1);
               pending_reports.push_back(entry);
            end
            clear_slots();
         end
      endfunction

      function void check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            failures++;
         end
      endfunction

      function void check_report(slot_report_type seen);
         slot_report_type want;
         if (pending_reports.size() == 0) begin
            $error("Report transfer for slot %0d arrived with none outstanding", seen.slot);
            failures++;
            return;
         end
         want = pending_reports.pop_front();
         check_field("report_slot", DATA_W'(want.slot), DATA_W'(seen.slot));
         check_field("max_us", want.max_us, seen.max_us);
         check_field("avg_us", want.avg_us, seen.avg_us);
         check_field("sample_count", want.sample_count, seen.sample_count);
         check_field("last", DATA_W'(want.last), DATA_W'(seen.last));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [CLK_W-1:0] csr_wr_data;
   logic req_valid;
   logic req_ready;
   logic req_kind;
   logic [ID_W-1:0] req_slot_id;
   logic [DATA_W-1:0] req_start_cycle;
   logic [DATA_W-1:0] req_end_cycle;
   logic rsp_valid;
   logic rsp_ready;
   logic [ID_W-1:0] rsp_report_slot;
   logic [DATA_W-1:0] rsp_max_us;
   logic [DATA_W-1:0] rsp_avg_us;
   logic [DATA_W-1:0] rsp_sample_count;
   logic rsp_last;

   latency_stats_board board = new();
   bit allow_gaps = 1'b1;
   bit hold_request = 1'b0;

   per_slot_latency_statistics_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_slot_id      (req_slot_id),
      .req_start_cycle  (req_start_cycle),
      .req_end_cycle    (req_end_cycle),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_report_slot  (rsp_report_slot),
      .rsp_max_us       (rsp_max_us),
      .rsp_avg_us       (rsp_avg_us),
      .rsp_sample_count (rsp_sample_count),
      .rsp_last         (rsp_last)
   );

   always #5 clock = ~clock;

   task automatic send_request(input logic kind, input logic [ID_W-1:0] slot_id,
                               input logic [DATA_W-1:0] start_cycle,
                               input logic [DATA_W-1:0] end_cycle);
      if (allow_gaps && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_slot_id <= slot_id;
      req_start_cycle <= start_cycle;
      req_end_cycle <= end_cycle;
      do @(posedge clock); while (!req_ready);
      board.note_request(kind, slot_id, start_cycle, end_cycle);
   endtask

   task automatic send_random_request();
      logic kind;
      logic [ID_W-1:0] slot_id;
      logic [DATA_W-1:0] start_cycle;
      logic [DATA_W-1:0] span;
      kind = ($urandom_range(13) == 0) ? KIND_REPORT : KIND_RECORD;
      if ($urandom_range(99) < 85)
         slot_id = ID_W'($urandom_range(NUM_SLOTS - 1));
      else
         slot_id = ID_W'($urandom_range(255));
      start_cycle = $urandom();
      case ($urandom_range(3))
         0: span = $urandom_range(2_000_000);
         1: span = $urandom_range(32'h00FF_FFFF);
         2: span = $urandom();
         default: span = ~DATA_W'($urandom_range(1000));
      endcase
      send_request(kind, slot_id, start_cycle, start_cycle + span);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_clock(input logic [CLK_W-1:0] mhz);
      csr_wr_en <= 1'b1;
      csr_wr_data <= mhz;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.clock_mhz = mhz;
   endtask

   initial begin : response_side
      int hold_left;
      slot_report_type seen;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            seen.slot = rsp_report_slot;
            seen.max_us = rsp_max_us;
            seen.avg_us = rsp_avg_us;
            seen.sample_count = rsp_sample_count;
            seen.last = rsp_last;
            board.check_report(seen);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(allow_gaps && $urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   initial begin
      #10ms;
      $display("per_slot_latency_statistics_unit regression: fail");
      $finish;
   end

   initial begin : stimulus
      logic [CLK_W-1:0] phase_mhz;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      req_valid <= 1'b0;
      req_kind <= KIND_RECORD;
      req_slot_id <= '0;
      req_start_cycle <= '0;
      req_end_cycle <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The clock register still holds its reset value of 480 MHz here.
      send_request(KIND_RECORD, 0, 0, 0);
      send_request(KIND_RECORD, 0, 0, 2400);
      send_request(KIND_RECORD, 0, 100, 579);
      send_request(KIND_RECORD, 7, 32'hFFFF_FFF0, 32'h0000_1000);
      send_request(KIND_RECORD, 7, 0, 32'hFFFF_FFFF);
      send_request(KIND_RECORD, 3, 32'hFFFF_FFFF, 0);
      send_request(KIND_RECORD, ID_W'(NUM_SLOTS), 0, 32'h0010_0000);
      send_request(KIND_RECORD, 8'hFF, 0, 32'hFFFF_FFFF);
      send_request(KIND_REPORT, 8'hFF, 32'hFFFF_FFFF, 32'h1234_5678);
      send_request(KIND_REPORT, 0, 0, 0);
      for (int s = 1; s < NUM_SLOTS - 1; s++)
         send_request(KIND_RECORD, ID_W'(s), DATA_W'(s), DATA_W'(s * 5000));
      send_request(KIND_REPORT, 8'h80, 0, 0);
      wait_drained();
      write_clock(0);
      send_request(KIND_RECORD, 2, 0, 960);
      send_request(KIND_REPORT, 0, 0, 0);
      wait_drained();
      write_clock(1);
      send_request(KIND_RECORD, 5, 1, 0);
      send_request(KIND_RECORD, 5, 1, 0);
      send_request(KIND_REPORT, 0, 0, 0);
      wait_drained();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: phase_mhz = 10'd1;
            1: phase_mhz = 10'd1023;
            2: phase_mhz = 10'd0;
            3: phase_mhz = FALLBACK_MHZ;
            4: phase_mhz = 10'd2;
            default: phase_mhz = CLK_W'($urandom_range(1, 1023));
         endcase
         write_clock(phase_mhz);
         allow_gaps = (phase != 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 1 && n == 10) begin
               // Stall the response side long enough that the block backs up into
               // its input while transfers keep being offered.
               hold_request = 1'b1;
               send_request(KIND_REPORT, 0, 0, 0);
            end else if (phase == 5 && n == PHASE_ITEMS / 2) begin
               wait_drained();
            end else begin
               send_random_request();
            end
         end
         send_request(KIND_REPORT, 0, 0, 0);
         wait_drained();
      end
      allow_gaps = 1'b1;

      if (board.failures == 0)
         $display("per_slot_latency_statistics_unit regression: pass");
      else
         $display("per_slot_latency_statistics_unit regression: fail");
      $finish;
   end

endmodule
